>>> rtl/float_log2_log10_approx_macros.svh
// ----------------------------------------------------------------------------
// float_log2_log10_approx assertion macros
// Shared concurrent assertion forms; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FLOAT_LOG2_LOG10_APPROX_MACROS_SVH
`define FLOAT_LOG2_LOG10_APPROX_MACROS_SVH

// same-cycle implication
`define FLA_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define FLA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Types and fixed-point constants of the double-precision log2/log10 unit.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int FRAC_BITS_DEF = 20;   // result fraction bits
    localparam int WORK_FRAC     = 40;   // internal fraction bits
    localparam int EXP_W         = 12;   // signed unbiased exponent
    localparam int MANT_W        = 53;   // Q1.52 with hidden one
    localparam int SQ_W          = 42;   // Q2.40 square of mantissa
    localparam int TOT_W         = EXP_W + 1 + WORK_FRAC;  // signed sum
    localparam int MAG_W         = TOT_W - 1;

    localparam logic [EXP_W-1:0] EXP_BIAS = 12'h400;

    // A = 0.3358287811 in Q0.32, round to nearest
    localparam logic [63:0] A_NUM  = 64'd3358287811;
    localparam logic [63:0] A_FULL = ((A_NUM << 32) + 64'd5000000000) / 64'd10000000000;
    localparam logic [31:0] COEF_A32 = A_FULL[31:0];

    // C = 0.65871759316667 in Q.40, long division in steps to stay in 64 bits
    localparam logic [63:0] C_NUM = 64'd65871759316667;
    localparam logic [63:0] C_DEN = 64'd100000000000000;
    localparam logic [63:0] C_Q1  = (C_NUM << 17) / C_DEN;
    localparam logic [63:0] C_R1  = (C_NUM << 17) % C_DEN;
    localparam logic [63:0] C_Q2  = (C_R1 << 17) / C_DEN;
    localparam logic [63:0] C_R2  = (C_R1 << 17) % C_DEN;
    localparam logic [63:0] C_Q3  = ((C_R2 << 6) + C_DEN / 2) / C_DEN;
    localparam logic [63:0] C_FULL = (C_Q1 << 23) + (C_Q2 << 6) + C_Q3;
    localparam logic [WORK_FRAC-1:0] COEF_C40 = C_FULL[WORK_FRAC-1:0];

    // 1/log2(10) in Q0.32, round to nearest
    localparam logic [63:0] I_NUM = 64'd10000000000000000;
    localparam logic [63:0] I_DEN = 64'd33219280948873626;
    localparam logic [63:0] I_Q1  = (I_NUM << 8) / I_DEN;
    localparam logic [63:0] I_R1  = (I_NUM << 8) % I_DEN;
    localparam logic [63:0] I_Q2  = (I_R1 << 8) / I_DEN;
    localparam logic [63:0] I_R2  = (I_R1 << 8) % I_DEN;
    localparam logic [63:0] I_Q3  = (I_R2 << 8) / I_DEN;
    localparam logic [63:0] I_R3  = (I_R2 << 8) % I_DEN;
    localparam logic [63:0] I_Q4  = ((I_R3 << 8) + I_DEN / 2) / I_DEN;
    localparam logic [63:0] I_FULL = (I_Q1 << 24) + (I_Q2 << 16) + (I_Q3 << 8) + I_Q4;
    localparam logic [31:0] INV_LOG2_10 = I_FULL[31:0];

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic {
        OP_LOG2  = 1'b0,
        OP_LOG10 = 1'b1
    } fla_op_t;

    typedef struct packed {
        logic        operation;
        logic [63:0] value_bits;
    } fla_req_t;

    typedef struct packed {
        logic signed [31:0] log_result;
        logic               is_nan;
    } fla_res_t;

    // normalized operand handed from the front end
    typedef struct packed {
        logic              op;
        logic              nan;
        logic [EXP_W-1:0]  expo;   // two's complement, exponent minus one
        logic [MANT_W-1:0] mant;
    } fla_nrm_t;

endpackage

>>> rtl/float_log2_log10_approx.sv
// ----------------------------------------------------------------------------
// float_log2_log10_approx
// Pipelined log2/log10 of an IEEE double, signed fixed-point result.
//
// Request channel (req_valid/req_stall/req) carries an operation select
// (0 log2, 1 log10) and a double bit pattern. Result channel
// (res_valid/res_stall/res) returns log_result with FRAC_BITS fraction
// bits plus is_nan for zero, negative, infinite or NaN operands.
// Nine register stages: two normalize, two mantissa square, two A*m^2 and
// sum, one magnitude, two log10 scaling and saturation. A request passes
// through them in order to res; one request per cycle while res_stall is low.
// Each stage has its own valid bit and moves when the stage after it has
// room, so bubbles close up while res_stall holds the output register;
// req_stall rises only once all nine stages are full.
// Reset clears the valid bits only; the datapath is not reset.
// ----------------------------------------------------------------------------
`include "float_log2_log10_approx_macros.svh"

module float_log2_log10_approx
    import fla_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  fla_req_t req,
    output logic     res_valid,
    input  logic     res_stall,
    output fla_res_t res
);

    localparam int SHIFT = WORK_FRAC - FRAC_BITS;

    // stage positions after the front end
    localparam int ST_SQP = 0;   // mantissa square partial products
    localparam int ST_SQ  = 1;   // mantissa square
    localparam int ST_AP  = 2;   // A*m^2 partial products
    localparam int ST_TOT = 3;   // signed sum
    localparam int ST_MAG = 4;   // magnitude
    localparam int ST_IP  = 5;   // log10 partial products
    localparam int ST_OUT = 6;   // output register
    localparam int NST    = 7;

    logic          nrm_valid;
    fla_nrm_t      nrm;
    logic [NST:0]  rdy;
    logic [NST-1:0] vld_reg;
    logic [NST-1:0] vld_next;
    logic [NST-1:0] vld_in;

    // stage registers
    logic             s3_op_reg,  s3_nan_reg;
    logic [TOT_W-1:0] s3_base_reg, s3_base_next;
    logic [41:0]      s3_hh_reg,  s3_hh_next;
    logic [52:0]      s3_hl_reg,  s3_hl_next;
    logic [63:0]      s3_ll_reg,  s3_ll_next;

    logic             s4_op_reg,  s4_nan_reg;
    logic [TOT_W-1:0] s4_base_reg;
    logic [SQ_W-1:0]  s4_sq_reg,  s4_sq_next;
    logic [105:0]     sq_sum;

    logic             s5_op_reg,  s5_nan_reg;
    logic [TOT_W-1:0] s5_base_reg;
    logic [SQ_W-1:0]  s5_ah_reg,  s5_ah_next;
    logic [63:0]      s5_al_reg,  s5_al_next;

    logic             s6_op_reg,  s6_nan_reg;
    logic [TOT_W-1:0] s6_tot_reg, s6_tot_next;
    logic [SQ_W-1:0]  asq;

    logic             s7_op_reg,  s7_nan_reg, s7_neg_reg, s7_neg_next;
    logic [MAG_W-1:0] s7_mag_reg, s7_mag_next;

    logic             s8_op_reg,  s8_nan_reg, s8_neg_reg;
    logic [MAG_W-1:0] s8_mag_reg;
    logic [63:0]      s8_il_reg,  s8_il_next;
    logic [MAG_W-1:0] s8_ih_reg,  s8_ih_next;

    fla_res_t         res_reg,    res_next;
    logic [MAG_W-1:0] scaled;
    logic [MAG_W-1:0] shifted;
    logic [31:0]      sat_val;

    fla_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .req       (req),
        .out_valid (nrm_valid),
        .out_stall (!rdy[ST_SQP]),
        .nrm       (nrm)
    );

    // elastic handshake: a stage loads when it is empty or the next one moves
    assign rdy[NST] = !res_stall;
    assign vld_in   = {vld_reg[NST-2:0], nrm_valid};

    genvar g;
    for (g = 0; g < NST; g++)
    begin : g_hs
        assign rdy[g]      = !vld_reg[g] || rdy[g+1];
        assign vld_next[g] = rdy[g] ? vld_in[g] : vld_reg[g];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // mantissa square split 21+32 bits; exponent/linear part in parallel
    always_comb
    begin
        s3_hh_next   = 42'(nrm.mant[52:32]) * 42'(nrm.mant[52:32]);
        s3_hl_next   = 53'(nrm.mant[52:32]) * 53'(nrm.mant[31:0]);
        s3_ll_next   = 64'(nrm.mant[31:0]) * 64'(nrm.mant[31:0]);
        // (exponent - 1) * 2^40 + 2m - C
        s3_base_next = {nrm.expo[EXP_W-1], nrm.expo, {WORK_FRAC{1'b0}}}
                     + TOT_W'(nrm.mant[MANT_W-1:11])
                     - TOT_W'(COEF_C40);
    end

    // high 42 bits of the 106-bit square
    always_comb
    begin
        sq_sum     = {s3_hh_reg, 64'd0} + 106'({s3_hl_reg, 33'd0}) + 106'(s3_ll_reg);
        s4_sq_next = sq_sum[105:64];
    end

    // A*m^2 split 10+32 bits
    always_comb
    begin
        s5_ah_next = SQ_W'(s4_sq_reg[41:32]) * SQ_W'(COEF_A32);
        s5_al_next = 64'(s4_sq_reg[31:0]) * 64'(COEF_A32);
    end

    always_comb
    begin
        asq         = s5_ah_reg + SQ_W'(s5_al_reg[63:32]);
        s6_tot_next = s5_base_reg - TOT_W'(asq);
    end

    always_comb
    begin
        s7_neg_next = s6_tot_reg[TOT_W-1];
        s7_mag_next = MAG_W'(s7_neg_next ? (TOT_W'(0) - s6_tot_reg) : s6_tot_reg);
    end

    // magnitude times 1/log2(10), split 20+32 bits
    always_comb
    begin
        s8_il_next = 64'(s7_mag_reg[31:0]) * 64'(INV_LOG2_10);
        s8_ih_next = MAG_W'(s7_mag_reg[MAG_W-1:32]) * MAG_W'(INV_LOG2_10);
    end

    // scale select, truncate to FRAC_BITS, saturate to 32 bits
    always_comb
    begin
        scaled  = (s8_op_reg == OP_LOG10) ? (s8_ih_reg + MAG_W'(s8_il_reg[63:32]))
                                          : s8_mag_reg;
        shifted = scaled >> SHIFT;
        if (s8_neg_reg)
        begin
            sat_val = (shifted > MAG_W'(SAT_NEG)) ? SAT_NEG : (32'd0 - shifted[31:0]);
        end
        else
        begin
            sat_val = (shifted > MAG_W'(SAT_POS)) ? SAT_POS : shifted[31:0];
        end
        res_next.is_nan     = s8_nan_reg;
        res_next.log_result = s8_nan_reg ? 32'sd0 : $signed(sat_val);
    end

    always_ff @(posedge clk)
    begin
        if (rdy[ST_SQP])
        begin
            s3_op_reg   <= nrm.op;
            s3_nan_reg  <= nrm.nan;
            s3_base_reg <= s3_base_next;
            s3_hh_reg   <= s3_hh_next;
            s3_hl_reg   <= s3_hl_next;
            s3_ll_reg   <= s3_ll_next;
        end
        if (rdy[ST_SQ])
        begin
            s4_op_reg   <= s3_op_reg;
            s4_nan_reg  <= s3_nan_reg;
            s4_base_reg <= s3_base_reg;
            s4_sq_reg   <= s4_sq_next;
        end
        if (rdy[ST_AP])
        begin
            s5_op_reg   <= s4_op_reg;
            s5_nan_reg  <= s4_nan_reg;
            s5_base_reg <= s4_base_reg;
            s5_ah_reg   <= s5_ah_next;
            s5_al_reg   <= s5_al_next;
        end
        if (rdy[ST_TOT])
        begin
            s6_op_reg   <= s5_op_reg;
            s6_nan_reg  <= s5_nan_reg;
            s6_tot_reg  <= s6_tot_next;
        end
        if (rdy[ST_MAG])
        begin
            s7_op_reg   <= s6_op_reg;
            s7_nan_reg  <= s6_nan_reg;
            s7_neg_reg  <= s7_neg_next;
            s7_mag_reg  <= s7_mag_next;
        end
        if (rdy[ST_IP])
        begin
            s8_op_reg   <= s7_op_reg;
            s8_nan_reg  <= s7_nan_reg;
            s8_neg_reg  <= s7_neg_reg;
            s8_mag_reg  <= s7_mag_reg;
            s8_il_reg   <= s8_il_next;
            s8_ih_reg   <= s8_ih_next;
        end
        if (rdy[ST_OUT])
        begin
            res_reg     <= res_next;
        end
    end

    assign res_valid = vld_reg[ST_OUT];
    assign res       = res_reg;

    // checks
    `FLA_ASSERT_IMP(a_nan_zero, res_valid && res.is_nan, res.log_result == 32'sd0,
        "nan result carries a nonzero value")
    `FLA_ASSERT_IMP(a_stall_full, req_stall, (&vld_reg) && res_stall,
        "request stalled while the pipeline has room")
    `FLA_ASSERT_IMP(a_sq_range, vld_reg[ST_SQ] && !s4_nan_reg, s4_sq_reg[41:40] != 2'b00,
        "mantissa square out of range, operand not normalized")
    `FLA_ASSERT_NEXT(a_drain, res_valid && !res_stall && !vld_reg[ST_OUT-1], !res_valid,
        "output stayed valid with nothing behind it")

endmodule

>>> rtl/fla_norm.sv
// ----------------------------------------------------------------------------
// fla_norm
// Two-stage front end: operand decode and leading-one normalization.
// ----------------------------------------------------------------------------
module fla_norm
    import fla_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  fla_req_t req,
    output logic     out_valid,
    input  logic     out_stall,
    output fla_nrm_t nrm
);

    typedef struct packed {
        logic        op;
        logic        nan;
        logic [10:0] bexp;
        logic [63:0] x;
        logic [5:0]  lz;
    } fla_nst_t;

    logic [1:0] vld_reg;
    logic [1:0] vld_next;
    logic       rdy1;
    logic       rdy2;
    fla_nst_t   s1_reg;
    fla_nst_t   s1_next;
    fla_nrm_t   s2_reg;
    fla_nrm_t   s2_next;
    logic [63:0] x2;
    logic [5:0]  lz2;

    assign rdy2     = !vld_reg[1] || !out_stall;
    assign rdy1     = !vld_reg[0] || rdy2;
    assign in_stall = !rdy1;
    assign vld_next = {rdy2 ? vld_reg[0] : vld_reg[1], rdy1 ? in_valid : vld_reg[0]};

    // stage 1: decode, coarse shift by 32/16/8
    always_comb
    begin
        s1_next.op   = req.operation;
        s1_next.bexp = req.value_bits[62:52];
        s1_next.nan  = req.value_bits[63] || (s1_next.bexp == 11'h7FF) ||
                       (req.value_bits[62:0] == '0);
        // subnormals drop the hidden one; normals already sit at bit 63
        s1_next.x    = (s1_next.bexp == '0) ? {req.value_bits[51:0], 12'd0}
                                            : {1'b1, req.value_bits[51:0], 11'd0};
        s1_next.lz   = '0;
        if (s1_next.x[63:32] == '0)
        begin
            s1_next.x     = s1_next.x << 32;
            s1_next.lz[5] = 1'b1;
        end
        if (s1_next.x[63:48] == '0)
        begin
            s1_next.x     = s1_next.x << 16;
            s1_next.lz[4] = 1'b1;
        end
        if (s1_next.x[63:56] == '0)
        begin
            s1_next.x     = s1_next.x << 8;
            s1_next.lz[3] = 1'b1;
        end
    end

    // stage 2: fine shift by 4/2/1, exponent
    always_comb
    begin
        x2  = s1_reg.x;
        lz2 = s1_reg.lz;
        if (x2[63:60] == '0)
        begin
            x2     = x2 << 4;
            lz2[2] = 1'b1;
        end
        if (x2[63:62] == '0)
        begin
            x2     = x2 << 2;
            lz2[1] = 1'b1;
        end
        if (!x2[63])
        begin
            x2     = x2 << 1;
            lz2[0] = 1'b1;
        end
        s2_next.op   = s1_reg.op;
        s2_next.nan  = s1_reg.nan;
        s2_next.mant = x2[63:63-MANT_W+1];
        // normal: bexp - 1024; subnormal: -1024 - lz
        s2_next.expo = {1'b0, s1_reg.bexp} - EXP_BIAS - EXP_W'(lz2);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy1)
        begin
            s1_reg <= s1_next;
        end
        if (rdy2)
        begin
            s2_reg <= s2_next;
        end
    end

    assign out_valid = vld_reg[1];
    assign nrm       = s2_reg;

endmodule
